// ===== src/cbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbpc_pkg
// Shared widths, reset values, sideband structs and helper functions for the
// clock and baud preflight check pipeline.
// ----------------------------------------------------------------------------
package cbpc_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned CODE_W    = 3;
    localparam int unsigned FAIL_W    = 9;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned SUM_W     = WORD_W + 1;
    localparam int unsigned SCALE_W   = 20;
    localparam int unsigned PROD_W    = WORD_W + SCALE_W;

    localparam logic [WORD_W-1:0]  RST_MAX_CORE  = 32'd84000000;
    localparam logic [WORD_W-1:0]  RST_MAX_SLOW  = 32'd42000000;
    localparam logic [WORD_W-1:0]  RST_MAX_FAST  = 32'd84000000;
    localparam logic [WORD_W-1:0]  RST_MAX_ERR   = 32'd20000;
    localparam logic [SCALE_W-1:0] PPM_SCALE     = 20'd1000000;
    localparam logic [HALF_W-1:0]  HALF_ONES     = 16'hFFFF;
    localparam logic [WORD_W-1:0]  WORD_ONES     = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0]  DIVISOR_MAX   = 32'h0000_FFFF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CORE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SLOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FAST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERR  = 3'd3;

    // Failure bit positions
    localparam int unsigned F_CLK_ZERO = 0;
    localparam int unsigned F_CLK_HIGH = 1;
    localparam int unsigned F_SLOW     = 2;
    localparam int unsigned F_FAST     = 3;
    localparam int unsigned F_DIV      = 4;
    localparam int unsigned F_ERR      = 5;
    localparam int unsigned F_ID       = 6;
    localparam int unsigned F_VREF     = 7;
    localparam int unsigned F_TEMP     = 8;

    // Sideband through the divisor divider
    typedef struct packed {
        logic [WORD_W-1:0] slow;
        logic [WORD_W-1:0] fast;
        logic [WORD_W-1:0] baud;
        logic [FAIL_W-1:0] fail;
        logic              inv;
    } t_side_a;

    // Sideband through the actual-baud divider
    typedef struct packed {
        logic [WORD_W-1:0] slow;
        logic [WORD_W-1:0] fast;
        logic [WORD_W-1:0] baud;
        logic [WORD_W-1:0] div;
        logic [FAIL_W-1:0] fail;
        logic              inv;
        logic              divbad;
    } t_side_b;

    // Sideband through the error divider
    typedef struct packed {
        logic [WORD_W-1:0] slow;
        logic [WORD_W-1:0] fast;
        logic [WORD_W-1:0] div;
        logic [WORD_W-1:0] actual;
        logic [FAIL_W-1:0] fail;
        logic              inv;
        logic              divbad;
    } t_side_c;

    // Codes 0..3 pass the clock through, 4..7 shift right by 1..4
    function automatic logic [WORD_W-1:0] bus_decode(input logic [WORD_W-1:0] clk,
                                                     input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] sh;
        sh = {1'b0, code[1:0]} + 3'd1;
        return code[2] ? (clk >> sh) : clk;
    endfunction

    function automatic logic half_ok(input logic [HALF_W-1:0] v);
        return (v != '0) && (v != HALF_ONES);
    endfunction

endpackage

// ===== src/cbpc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// cbpc_div_pipe
// Pipelined restoring divider, one quotient bit per register stage. A
// sideband word rides along with each transaction.
// ----------------------------------------------------------------------------
module cbpc_div_pipe #(
    parameter int unsigned NW = 32,
    parameter int unsigned DW = 32,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          st_v    [0:NW];
    logic [DW-1:0] st_rem  [0:NW];
    logic [NW-1:0] st_dq   [0:NW];
    logic [DW-1:0] st_den  [0:NW];
    logic [SW-1:0] st_side [0:NW];

    // Feed the first stage
    assign st_v[0]    = i_valid;
    assign st_rem[0]  = '0;
    assign st_dq[0]   = i_num;
    assign st_den[0]  = i_den;
    assign st_side[0] = i_side;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;

        // Trial subtract of the next dividend bit
        always_comb begin
            trial = {st_rem[k], st_dq[k][NW-1]};
            ge    = trial >= {1'b0, st_den[k]};
            diff  = trial - {1'b0, st_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                st_v[k+1] <= 1'b0;
            end else begin
                st_v[k+1] <= st_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            st_rem[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            st_dq[k+1]   <= {st_dq[k][NW-2:0], ge};
            st_den[k+1]  <= st_den[k];
            st_side[k+1] <= st_side[k];
        end
    end

    assign o_valid = st_v[NW];
    assign o_quo   = st_dq[NW];
    assign o_side  = st_side[NW];

endmodule

// ===== src/clock_and_baud_preflight_check_core.sv =====
// ----------------------------------------------------------------------------
// clock_and_baud_preflight_check_core
// Decodes bus clocks, derives a rounded baud divisor, actual baud and ppm
// error, and reports nine failure bits with a pass flag.
// ----------------------------------------------------------------------------
// A transaction is taken on every cycle that i_start is high; o_busy is never
// asserted. Each result appears on o_done for one cycle, after passing through
// three one-bit-per-stage dividers (33 stages for the divisor, 32 for the
// actual baud, 52 for the ppm error) plus five stages of decode, compare,
// subtract, multiply and output. Results leave in start order, one per
// cycle at most, and must be captured when o_done is high. Limit registers
// are written through i_cfg_we/i_cfg_idx/i_cfg_data and should only change
// while no transaction is in flight.
module clock_and_baud_preflight_check_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    output logic                               o_done,
    input  logic                               i_cfg_we,
    input  logic [cbpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cbpc_pkg::WORD_W-1:0]        i_cfg_data,
    input  logic [cbpc_pkg::WORD_W-1:0]        i_system_clock,
    input  logic [cbpc_pkg::CODE_W-1:0]        i_slow_bus_code,
    input  logic [cbpc_pkg::CODE_W-1:0]        i_fast_bus_code,
    input  logic [cbpc_pkg::WORD_W-1:0]        i_wanted_baud,
    input  logic [cbpc_pkg::WORD_W-1:0]        i_id_word_low,
    input  logic [cbpc_pkg::WORD_W-1:0]        i_id_word_mid,
    input  logic [cbpc_pkg::WORD_W-1:0]        i_id_word_high,
    input  logic [cbpc_pkg::HALF_W-1:0]        i_vref_code,
    input  logic [cbpc_pkg::HALF_W-1:0]        i_temp_code_low,
    input  logic [cbpc_pkg::HALF_W-1:0]        i_temp_code_high,
    output logic [cbpc_pkg::WORD_W-1:0]        o_slow_bus_clock,
    output logic [cbpc_pkg::WORD_W-1:0]        o_fast_bus_clock,
    output logic [cbpc_pkg::WORD_W-1:0]        o_baud_divisor,
    output logic [cbpc_pkg::WORD_W-1:0]        o_actual_baud,
    output logic [cbpc_pkg::WORD_W-1:0]        o_error_ppm,
    output logic [cbpc_pkg::FAIL_W-1:0]        o_failure_bits,
    output logic                               o_passed
);

    localparam int unsigned SA_W = $bits(cbpc_pkg::t_side_a);
    localparam int unsigned SB_W = $bits(cbpc_pkg::t_side_b);
    localparam int unsigned SC_W = $bits(cbpc_pkg::t_side_c);

    logic [cbpc_pkg::WORD_W-1:0] r_max_core, r_max_slow, r_max_fast, r_max_err;

    // Limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_core <= cbpc_pkg::RST_MAX_CORE;
            r_max_slow <= cbpc_pkg::RST_MAX_SLOW;
            r_max_fast <= cbpc_pkg::RST_MAX_FAST;
            r_max_err  <= cbpc_pkg::RST_MAX_ERR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cbpc_pkg::REG_MAX_CORE: r_max_core <= i_cfg_data;
                cbpc_pkg::REG_MAX_SLOW: r_max_slow <= i_cfg_data;
                cbpc_pkg::REG_MAX_FAST: r_max_fast <= i_cfg_data;
                cbpc_pkg::REG_MAX_ERR:  r_max_err  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // ---------------- Stage 1: decode, checks, rounding sum ----------------
    cbpc_pkg::t_side_a           n_s1_side;
    logic [cbpc_pkg::SUM_W-1:0]  n_s1_sum;
    logic                        r_s1_valid;
    cbpc_pkg::t_side_a           r_s1_side;
    logic [cbpc_pkg::SUM_W-1:0]  r_s1_sum;

    always_comb begin
        n_s1_side      = '0;
        n_s1_side.slow = cbpc_pkg::bus_decode(i_system_clock, i_slow_bus_code);
        n_s1_side.fast = cbpc_pkg::bus_decode(i_system_clock, i_fast_bus_code);
        n_s1_side.baud = i_wanted_baud;
        n_s1_side.inv  = (i_wanted_baud == '0) || (n_s1_side.slow == '0);
        n_s1_side.fail[cbpc_pkg::F_CLK_ZERO] = (i_system_clock == '0);
        n_s1_side.fail[cbpc_pkg::F_CLK_HIGH] = (i_system_clock > r_max_core);
        n_s1_side.fail[cbpc_pkg::F_SLOW]     = (n_s1_side.slow > r_max_slow);
        n_s1_side.fail[cbpc_pkg::F_FAST]     = (n_s1_side.fast > r_max_fast);
        n_s1_side.fail[cbpc_pkg::F_DIV]      = n_s1_side.inv;
        n_s1_side.fail[cbpc_pkg::F_ID] =
            ((i_id_word_low == '0) && (i_id_word_mid == '0) && (i_id_word_high == '0)) ||
            ((i_id_word_low == cbpc_pkg::WORD_ONES) && (i_id_word_mid == cbpc_pkg::WORD_ONES)
             && (i_id_word_high == cbpc_pkg::WORD_ONES));
        n_s1_side.fail[cbpc_pkg::F_VREF] = !cbpc_pkg::half_ok(i_vref_code);
        n_s1_side.fail[cbpc_pkg::F_TEMP] = !cbpc_pkg::half_ok(i_temp_code_low)
            || !cbpc_pkg::half_ok(i_temp_code_high) || (i_temp_code_low == i_temp_code_high);
        n_s1_sum = {1'b0, n_s1_side.slow} + {2'b00, i_wanted_baud[cbpc_pkg::WORD_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_side <= n_s1_side;
        r_s1_sum  <= n_s1_sum;
    end

    // ---------------- Divisor divider ----------------
    logic                        a_valid;
    logic [cbpc_pkg::SUM_W-1:0]  a_quo;
    logic [SA_W-1:0]             a_side_bits;
    cbpc_pkg::t_side_a           a_side;

    cbpc_div_pipe #(
        .NW (cbpc_pkg::SUM_W),
        .DW (cbpc_pkg::WORD_W),
        .SW (SA_W)
    ) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_num   (r_s1_sum),
        .i_den   (r_s1_side.baud),
        .i_side  (r_s1_side),
        .o_valid (a_valid),
        .o_quo   (a_quo),
        .o_side  (a_side_bits)
    );

    assign a_side = cbpc_pkg::t_side_a'(a_side_bits);

    // ---------------- Stage 2: divisor range check ----------------
    cbpc_pkg::t_side_b n_s2_side;
    logic              r_s2_valid;
    cbpc_pkg::t_side_b r_s2_side;

    always_comb begin
        n_s2_side        = '0;
        n_s2_side.slow   = a_side.slow;
        n_s2_side.fast   = a_side.fast;
        n_s2_side.baud   = a_side.baud;
        n_s2_side.div    = a_quo[cbpc_pkg::WORD_W-1:0];
        n_s2_side.inv    = a_side.inv;
        n_s2_side.divbad = a_side.inv || (n_s2_side.div == '0)
                           || (n_s2_side.div > cbpc_pkg::DIVISOR_MAX);
        n_s2_side.fail   = a_side.fail;
        n_s2_side.fail[cbpc_pkg::F_DIV] = n_s2_side.divbad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_side <= n_s2_side;
    end

    // ---------------- Actual baud divider ----------------
    logic                        b_valid;
    logic [cbpc_pkg::WORD_W-1:0] b_quo;
    logic [SB_W-1:0]             b_side_bits;
    cbpc_pkg::t_side_b           b_side;

    cbpc_div_pipe #(
        .NW (cbpc_pkg::WORD_W),
        .DW (cbpc_pkg::HALF_W),
        .SW (SB_W)
    ) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .i_num   (r_s2_side.slow),
        .i_den   (r_s2_side.div[cbpc_pkg::HALF_W-1:0]),
        .i_side  (r_s2_side),
        .o_valid (b_valid),
        .o_quo   (b_quo),
        .o_side  (b_side_bits)
    );

    assign b_side = cbpc_pkg::t_side_b'(b_side_bits);

    // ---------------- Stage 3: absolute difference ----------------
    cbpc_pkg::t_side_c           n_s3_side;
    logic                        r_s3_valid;
    cbpc_pkg::t_side_c           r_s3_side;
    logic [cbpc_pkg::WORD_W-1:0] r_s3_diff;
    logic [cbpc_pkg::WORD_W-1:0] r_s3_baud;

    always_comb begin
        n_s3_side        = '0;
        n_s3_side.slow   = b_side.slow;
        n_s3_side.fast   = b_side.fast;
        n_s3_side.div    = b_side.div;
        n_s3_side.actual = b_quo;
        n_s3_side.fail   = b_side.fail;
        n_s3_side.inv    = b_side.inv;
        n_s3_side.divbad = b_side.divbad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_side <= n_s3_side;
        r_s3_diff <= (b_quo > b_side.baud) ? (b_quo - b_side.baud) : (b_side.baud - b_quo);
        r_s3_baud <= b_side.baud;
    end

    // ---------------- Stage 4: scale to ppm ----------------
    logic                        r_s4_valid;
    cbpc_pkg::t_side_c           r_s4_side;
    logic [cbpc_pkg::PROD_W-1:0] r_s4_prod;
    logic [cbpc_pkg::WORD_W-1:0] r_s4_baud;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_side <= r_s3_side;
        r_s4_prod <= {{cbpc_pkg::SCALE_W{1'b0}}, r_s3_diff}
                     * {{cbpc_pkg::WORD_W{1'b0}}, cbpc_pkg::PPM_SCALE};
        r_s4_baud <= r_s3_baud;
    end

    // ---------------- Error divider ----------------
    logic                        c_valid;
    logic [cbpc_pkg::PROD_W-1:0] c_quo;
    logic [SC_W-1:0]             c_side_bits;
    cbpc_pkg::t_side_c           c_side;

    cbpc_div_pipe #(
        .NW (cbpc_pkg::PROD_W),
        .DW (cbpc_pkg::WORD_W),
        .SW (SC_W)
    ) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s4_valid),
        .i_num   (r_s4_prod),
        .i_den   (r_s4_baud),
        .i_side  (r_s4_side),
        .o_valid (c_valid),
        .o_quo   (c_quo),
        .o_side  (c_side_bits)
    );

    assign c_side = cbpc_pkg::t_side_c'(c_side_bits);

    // ---------------- Stage 5: error limit and output ----------------
    logic [cbpc_pkg::WORD_W-1:0] n_err;
    logic [cbpc_pkg::FAIL_W-1:0] n_fail;

    always_comb begin
        n_err  = c_side.divbad ? '0 : c_quo[cbpc_pkg::WORD_W-1:0];
        n_fail = c_side.fail;
        n_fail[cbpc_pkg::F_ERR] = !c_side.divbad && (n_err > r_max_err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_slow_bus_clock <= c_side.slow;
        o_fast_bus_clock <= c_side.fast;
        o_baud_divisor   <= c_side.inv ? '0 : c_side.div;
        o_actual_baud    <= c_side.divbad ? '0 : c_side.actual;
        o_error_ppm      <= n_err;
        o_failure_bits   <= n_fail;
        o_passed         <= (n_fail == '0);
    end

`ifndef NO_ASSERTIONS
    // Pass flag agrees with the failure bits
    a_pass_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_passed == (o_failure_bits == '0)))
        else $error("pass flag disagrees with failure bits");

    // A good divisor lies in range
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_failure_bits[cbpc_pkg::F_DIV]) |->
        (o_baud_divisor != '0 && o_baud_divisor <= cbpc_pkg::DIVISOR_MAX))
        else $error("divisor out of range without failure");

    // A bad divisor zeroes baud and error and masks the error check
    a_div_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_failure_bits[cbpc_pkg::F_DIV]) |->
        (o_actual_baud == '0 && o_error_ppm == '0 && !o_failure_bits[cbpc_pkg::F_ERR]))
        else $error("bad divisor leaked baud or error");

    // Error bit tracks the limit
    a_err_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_failure_bits[cbpc_pkg::F_DIV]) |->
        (o_failure_bits[cbpc_pkg::F_ERR] == (o_error_ppm > r_max_err)))
        else $error("error bit disagrees with limit");
`endif

endmodule
